// ----- rtl/tccw_pkg.sv -----
// ============================================================================
// tccw_pkg
// Shared types and constants for the text console character writer: screen
// geometry, command and register codes, control characters, transaction
// payloads and the cell index helper.
// ============================================================================
package tccw_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);

   // Field widths
   localparam int CMD_W   = 2;
   localparam int CHAR_W  = 8;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = 16;
   localparam int POS_W   = 11;
   localparam int INDEX_W = ROW_W + COL_W;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEXT_ATTR       = 1'd0,
      CSR_DISPLAY_PRESENT = 1'd1
   } csr_index_type;

   // Commands
   typedef enum logic [CMD_W-1:0] {
      CMD_PUT_CHAR = 2'd0,
      CMD_CLEAR    = 2'd1,
      CMD_PUT_AT   = 2'd2,
      CMD_READ_AT  = 2'd3
   } cmd_type;

   // Control characters
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
   localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

   // Transaction payloads
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] char_code;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] read_cell;
      logic              scrolled;
   } rsp_type;

   // Linear cell index row * COLUMNS + col (fits 12 bits for this geometry)
   function automatic logic [INDEX_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] c);
      logic [INDEX_W-1:0] prod;
      prod = INDEX_W'(r) * INDEX_W'(COLUMNS);
      return prod + INDEX_W'(c);
   endfunction

endpackage

// ----- rtl/text_console_char_writer.sv -----
// ============================================================================
// text_console_char_writer
// Teletype-style text screen: a cell store with a cursor, driven by a small
// sequencer around one cell index unit and a single-port-write cell memory.
// ============================================================================
// Flow: an accepted request is registered and run in S_EXEC, which waits
//   while the result port stalls; put-character, put-at and absent-display
//   commands load the result there, read-at via S_DONE (registered read).
// Clear runs S_FILL, a scrolling put-character S_SCROLL then S_FILL, one
//   cell per cycle; no new request is taken before the result is loaded.
// Reset: synchronous; afterwards an init sweep writes CELL_COUNT blank
//   cells while req_stall stays high (configuration writes are taken).
module text_console_char_writer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tccw_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tccw_pkg::rsp_type                rsp_payload,
   input  logic                             csr_write_en,
   input  logic [tccw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tccw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tccw_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_SCROLL,
      S_FILL,
      S_DONE
   } state_type;

   // Registers
   state_type          state_ff,        state_in;
   logic [CNT_W-1:0]   cnt_ff,          cnt_in;
   logic [ROW_W-1:0]   cursor_row_ff,   cursor_row_in;
   logic [COL_W-1:0]   cursor_col_ff,   cursor_col_in;
   req_type            req_ff,          req_in;
   logic               scrolled_ff,     scrolled_in;
   logic               rsp_valid_ff,    rsp_valid_in;
   rsp_type            rsp_payload_ff,  rsp_payload_in;
   logic [ATTR_W-1:0]  text_attr_ff;
   logic               present_ff;

   // Cell memory
   logic [CELL_W-1:0]  cell_mem [CELL_COUNT];
   logic [CELL_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [CELL_W-1:0]  mem_wdata;

   // Put-character decode
   logic [ROW_W-1:0]   pc_row;
   logic [COL_W-1:0]   pc_col;
   logic               pc_scroll;
   logic               pc_we;
   logic [CHAR_W-1:0]  pc_char;
   logic [ROW_W-1:0]   op_row;
   logic [COL_W-1:0]   op_col;

   // Shared cell index unit
   logic               at_cmd;
   logic               in_range;
   logic [ROW_W-1:0]   idx_row;
   logic [COL_W-1:0]   idx_col;
   logic [INDEX_W-1:0] idx_full;
   logic [ADDR_W-1:0]  idx_addr;
   logic               out_free;

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // Cursor movement and cell write for one put-character
   always_comb begin
      logic [COL_W:0] col_x;
      logic [ROW_W:0] row_x;
      col_x   = {1'b0, cursor_col_ff};
      row_x   = {1'b0, cursor_row_ff};
      pc_we   = 1'b0;
      pc_char = req_ff.char_code;
      op_row  = cursor_row_ff;
      op_col  = cursor_col_ff;
      case (req_ff.char_code)
         CH_LF: begin
            col_x = '0;
            row_x = row_x + (ROW_W+1)'(1);
         end
         CH_CR: begin
            col_x = '0;
         end
         CH_TAB: begin
            col_x = (col_x + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
         end
         CH_BS: begin
            if (cursor_col_ff != '0) begin
               col_x   = col_x - (COL_W+1)'(1);
               pc_we   = 1'b1;
               pc_char = CH_SPACE;
               op_col  = cursor_col_ff - COL_W'(1);
            end else if (cursor_row_ff != '0) begin
               row_x   = row_x - (ROW_W+1)'(1);
               col_x   = (COL_W+1)'(COLUMNS - 1);
               pc_we   = 1'b1;
               pc_char = CH_SPACE;
               op_row  = cursor_row_ff - ROW_W'(1);
               op_col  = COL_W'(COLUMNS - 1);
            end
         end
         default: begin
            pc_we = 1'b1;
            col_x = col_x + (COL_W+1)'(1);
         end
      endcase
      // line wrap, then scroll when the cursor passes the last row
      if (col_x >= (COL_W+1)'(COLUMNS)) begin
         col_x = '0;
         row_x = row_x + (ROW_W+1)'(1);
      end
      pc_scroll = (row_x >= (ROW_W+1)'(ROWS));
      if (pc_scroll) begin
         row_x = (ROW_W+1)'(ROWS - 1);
      end
      pc_row = row_x[ROW_W-1:0];
      pc_col = col_x[COL_W-1:0];
   end

   // Cell index unit, shared by put-character, put-at and read-at
   assign at_cmd   = (req_ff.cmd == CMD_PUT_AT) || (req_ff.cmd == CMD_READ_AT);
   assign idx_row  = at_cmd ? req_ff.row : op_row;
   assign idx_col  = at_cmd ? req_ff.col : op_col;
   assign idx_full = cell_index(idx_row, idx_col);
   assign idx_addr = idx_full[ADDR_W-1:0];
   assign in_range = ({1'b0, req_ff.col} < (COL_W+1)'(COLUMNS)) &&
                     ({1'b0, req_ff.row} < (ROW_W+1)'(ROWS));

   // Sequencer next state
   always_comb begin
      logic               load_rsp;
      logic [CELL_W-1:0]  rsp_cell;
      logic               rsp_scr;
      logic [INDEX_W-1:0] pos_full;
      load_rsp       = 1'b0;
      rsp_cell       = '0;
      rsp_scr        = 1'b0;
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cursor_row_in  = cursor_row_ff;
      cursor_col_in  = cursor_col_ff;
      req_in         = req_ff;
      scrolled_in    = scrolled_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = idx_addr;
      mem_raddr      = idx_addr;
      mem_wdata      = {text_attr_ff, CH_SPACE};

      case (state_ff)
         // blank the store after reset
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[ADDR_W-1:0];
            mem_wdata = RESET_CELL;
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               scrolled_in = 1'b0;
               state_in    = S_IDLE;
               case (req_ff.cmd)
                  CMD_PUT_CHAR: begin
                     if (present_ff) begin
                        cursor_row_in = pc_row;
                        cursor_col_in = pc_col;
                        mem_we        = pc_we;
                        mem_wdata     = {text_attr_ff, pc_char};
                        if (pc_scroll) begin
                           scrolled_in = 1'b1;
                           cnt_in      = '0;
                           state_in    = S_SCROLL;
                        end else begin
                           load_rsp = 1'b1;
                        end
                     end else begin
                        load_rsp = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     if (present_ff) begin
                        cursor_row_in = '0;
                        cursor_col_in = '0;
                        cnt_in        = '0;
                        state_in      = S_FILL;
                     end else begin
                        load_rsp = 1'b1;
                     end
                  end
                  CMD_PUT_AT: begin
                     mem_we    = in_range;
                     mem_wdata = {text_attr_ff, req_ff.char_code};
                     load_rsp  = 1'b1;
                  end
                  default: begin
                     mem_re   = 1'b1;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // move every row up one: read one row ahead, write the registered cell in the next cycle
         S_SCROLL: begin
            if (cnt_ff < CNT_W'(COPY_COUNT)) begin
               mem_re    = 1'b1;
               mem_raddr = ADDR_W'(cnt_ff + CNT_W'(COLUMNS));
            end
            if (cnt_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = ADDR_W'(cnt_ff - CNT_W'(1));
               mem_wdata = rd_data_ff;
            end
            if (cnt_ff == CNT_W'(COPY_COUNT)) begin
               state_in = S_FILL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         // blank cells from the counter to the end of the store
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[ADDR_W-1:0];
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               rsp_scr  = scrolled_ff;
               if ((req_ff.cmd == CMD_READ_AT) && in_range) begin
                  rsp_cell = rd_data_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // result transaction from the cursor after the step
      pos_full = cell_index(cursor_row_in, cursor_col_in);
      if (load_rsp) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.cursor_pos = pos_full[POS_W-1:0];
         rsp_payload_in.read_cell  = rsp_cell;
         rsp_payload_in.scrolled   = rsp_scr;
      end
   end

   // Sequencer, cursor, configuration and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cnt_ff        <= '0;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         scrolled_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         text_attr_ff  <= RESET_ATTR;
         present_ff    <= 1'b1;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         scrolled_ff   <= scrolled_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_TEXT_ATTR:       text_attr_ff <= csr_wdata[ATTR_W-1:0];
               CSR_DISPLAY_PRESENT: present_ff   <= csr_wdata[0];
               default:             ;
            endcase
         end
      end
      req_ff         <= req_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Cell memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cell_mem[mem_raddr];
      end
   end

endmodule

// ----- test/tccw_console_checker.sv -----
// ============================================================================
// tccw_console_checker
// Watches the request, result and register ports of the text console writer.
// A behavioral copy of the screen store and cursor predicts the result of
// each accepted request, and every accepted result is compared field by field
// against the oldest prediction still waiting.
// ============================================================================
`timescale 1ns / 100ps

module tccw_console_checker
   import tccw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_payload,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending_count
);

   // Shadow screen, cursor and register copies
   logic [CELL_W-1:0] cells [CELL_COUNT];
   int unsigned       cur_row;
   int unsigned       cur_col;
   logic [ATTR_W-1:0] attr;
   logic              disp_on;
   int                errors;

   // Predicted results, oldest first
   rsp_type console_results [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      errors        = 0;
   end

   function automatic logic [CELL_W-1:0] cell_of(input logic [CHAR_W-1:0] ch);
      return {attr, ch};
   endfunction

   function automatic void blank_and_home();
      for (int i = 0; i < CELL_COUNT; i++)
         cells[i] = cell_of(CH_SPACE);
      cur_row = 0;
      cur_col = 0;
   endfunction

   // Teletype write of one byte; returns 1 when the screen scrolled up
   function automatic logic put_character(input logic [CHAR_W-1:0] ch);
      case (ch)
         CH_LF: begin
            cur_col = 0;
            cur_row++;
         end
         CH_CR: cur_col = 0;
         CH_TAB: cur_col = (cur_col + 8) & ~32'd7;
         CH_BS: begin
            if (cur_col > 0) begin
               cur_col--;
               cells[cur_row * COLUMNS + cur_col] = cell_of(CH_SPACE);
            end else if (cur_row > 0) begin
               cur_row--;
               cur_col = COLUMNS - 1;
               cells[cur_row * COLUMNS + cur_col] = cell_of(CH_SPACE);
            end
         end
         default: begin
            cells[cur_row * COLUMNS + cur_col] = cell_of(ch);
            cur_col++;
         end
      endcase
      // wrap at the right edge
      if (cur_col >= COLUMNS) begin
         cur_col = 0;
         cur_row++;
      end
      if (cur_row < ROWS)
         return 1'b0;
      // scroll up one line, blank bottom row
      for (int i = 0; i < COPY_COUNT; i++)
         cells[i] = cells[i + COLUMNS];
      for (int i = COPY_COUNT; i < CELL_COUNT; i++)
         cells[i] = cell_of(CH_SPACE);
      cur_row = ROWS - 1;
      return 1'b1;
   endfunction

   // Apply one command to the shadow state and build its result
   function automatic rsp_type console_command(input req_type t);
      rsp_type     r;
      int unsigned c;
      int unsigned w;
      r = '0;
      c = t.col;
      w = t.row;
      case (cmd_type'(t.cmd))
         CMD_PUT_CHAR: if (disp_on) r.scrolled = put_character(t.char_code);
         CMD_CLEAR:    if (disp_on) blank_and_home();
         CMD_PUT_AT:   if (c < COLUMNS && w < ROWS) cells[w * COLUMNS + c] = cell_of(t.char_code);
         default:      if (c < COLUMNS && w < ROWS) r.read_cell = cells[w * COLUMNS + c];
      endcase
      r.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
      return r;
   endfunction

   // Sample all ports at the rising edge
   always @(posedge clock) begin : watch
      rsp_type want;
      logic    bad;
      if (reset) begin
         attr    = RESET_ATTR;
         disp_on = 1'b1;
         blank_and_home();
         console_results.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_TEXT_ATTR:       attr = csr_wdata;
               CSR_DISPLAY_PRESENT: disp_on = csr_wdata[0];
               default:             ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (console_results.size() == 0) begin
               $error("result transaction with nothing expected: pos %0d cell %h scrolled %0b",
                      rsp_payload.cursor_pos, rsp_payload.read_cell, rsp_payload.scrolled);
               errors++;
            end else begin
               want = console_results.pop_front();
               bad  = 1'b0;
               if (rsp_payload.cursor_pos !== want.cursor_pos) begin
                  $error("cursor_pos: expected %0d, actual %0d",
                         want.cursor_pos, rsp_payload.cursor_pos);
                  bad = 1'b1;
               end
               if (rsp_payload.read_cell !== want.read_cell) begin
                  $error("read_cell: expected %h, actual %h",
                         want.read_cell, rsp_payload.read_cell);
                  bad = 1'b1;
               end
               if (rsp_payload.scrolled !== want.scrolled) begin
                  $error("scrolled: expected %0b, actual %0b",
                         want.scrolled, rsp_payload.scrolled);
                  bad = 1'b1;
               end
               if (bad)
                  errors++;
            end
         end
         if (req_valid && !req_stall)
            console_results.push_back(console_command(req_payload));
      end
      pending_count <= console_results.size();
      fail_count    <= errors;
   end

endmodule

// ----- test/tb_text_console_char_writer.sv -----
// ============================================================================
// tb_text_console_char_writer
// Drives the text console writer with a short directed sequence of control
// characters, edge positions and clears, then random command traffic and
// character streams across several register settings, with random idle
// cycles on both channels. The checker instance predicts and compares.
// ============================================================================
`timescale 1ns / 100ps

module tb_text_console_char_writer;
   import tccw_pkg::*;

   logic                   clock;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   req_type                req_payload  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;
   int                     fail_count;
   int                     pending_count;
   bit                     idle_on      = 1'b1;

   text_console_char_writer i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   tccw_console_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard limit on run time
   initial begin
      #60_000_000;
      $display("text_console_char_writer test failed");
      $finish;
   end

   // Random result-side stall bursts
   initial begin : result_backpressure
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (!idle_on) begin
            hold = 0;
            rsp_stall <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            hold = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type console_req(input cmd_type cmd, input logic [CHAR_W-1:0] ch,
                                           input int c, input int r);
      req_type t;
      t.cmd       = cmd;
      t.char_code = ch;
      t.col       = COL_W'(c);
      t.row       = ROW_W'(r);
      return t;
   endfunction

   // Put-character transaction, weighted toward line and cursor controls
   function automatic req_type text_stream_char();
      int                k;
      logic [CHAR_W-1:0] ch;
      k = $urandom_range(0, 99);
      if (k < 25)      ch = CH_LF;
      else if (k < 30) ch = CH_CR;
      else if (k < 40) ch = CH_TAB;
      else if (k < 48) ch = CH_BS;
      else             ch = CHAR_W'($urandom_range(0, 255));
      return console_req(CMD_PUT_CHAR, ch, $urandom_range(0, 127), $urandom_range(0, 31));
   endfunction

   // Any command; positions mostly on screen, sometimes anywhere
   function automatic req_type mixed_command();
      int k;
      int c;
      int r;
      k = $urandom_range(0, 99);
      c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, COLUMNS - 1);
      r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, ROWS - 1);
      if (k < 3)
         return console_req(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)), c, r);
      else if (k < 33)
         return console_req(CMD_PUT_AT, CHAR_W'($urandom_range(0, 255)), c, r);
      else if (k < 65)
         return console_req(CMD_READ_AT, CHAR_W'($urandom_range(0, 255)), c, r);
      return text_stream_char();
   endfunction

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // One request transaction, then maybe a short idle burst
   task automatic send_item(input req_type t);
      @(negedge clock);
      req_payload <= t;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (idle_on && $urandom_range(0, 3) == 0)
         idle_sender($urandom_range(1, 3));
   endtask

   // Hold off until every predicted result has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Random mix of single commands and bursts of text
   task automatic run_traffic(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 3) begin
            burst = $urandom_range(5, 30);
            repeat (burst) send_item(text_stream_char());
            sent += burst;
         end else begin
            send_item(mixed_command());
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty screen, control codes, edges, out-of-range positions
      send_item(console_req(CMD_READ_AT, 8'h00, 0, 0));
      send_item(console_req(CMD_READ_AT, 8'hFF, 127, 31));
      send_item(console_req(CMD_PUT_CHAR, CH_BS, 0, 0));        // backspace at home
      send_item(console_req(CMD_PUT_CHAR, 8'h41, 0, 0));
      send_item(console_req(CMD_PUT_CHAR, 8'hFF, 127, 31));
      send_item(console_req(CMD_PUT_CHAR, 8'h00, 0, 0));
      send_item(console_req(CMD_PUT_CHAR, CH_TAB, 0, 0));
      send_item(console_req(CMD_PUT_CHAR, CH_BS, 0, 0));
      send_item(console_req(CMD_READ_AT, 8'h00, 7, 0));
      send_item(console_req(CMD_PUT_CHAR, CH_CR, 0, 0));
      send_item(console_req(CMD_PUT_CHAR, CH_LF, 0, 0));
      send_item(console_req(CMD_PUT_CHAR, CH_BS, 0, 0));        // back into previous row
      send_item(console_req(CMD_PUT_CHAR, CH_TAB, 0, 0));       // tab past the end wraps
      send_item(console_req(CMD_PUT_AT, 8'h7E, COLUMNS - 1, ROWS - 1));
      send_item(console_req(CMD_PUT_AT, 8'h58, COLUMNS, 0));
      send_item(console_req(CMD_PUT_AT, 8'h58, 0, ROWS));
      send_item(console_req(CMD_PUT_AT, 8'hFF, 127, 31));
      send_item(console_req(CMD_READ_AT, 8'h00, COLUMNS - 1, ROWS - 1));
      send_item(console_req(CMD_READ_AT, 8'h00, COLUMNS, 0));
      send_item(console_req(CMD_READ_AT, 8'h00, 0, ROWS));
      send_item(console_req(CMD_CLEAR, 8'hFF, 127, 31));
      send_item(console_req(CMD_READ_AT, 8'h00, COLUMNS - 1, ROWS - 1));
      send_item(console_req(CMD_READ_AT, 8'h00, 0, 0));
      drain_results();

      // Bright attribute
      write_reg(CSR_TEXT_ATTR, 8'hFF);
      run_traffic(80);
      drain_results();

      // Display absent: only put-at and read-at act
      write_reg(CSR_DISPLAY_PRESENT, 8'h00);
      write_reg(CSR_TEXT_ATTR, 8'h00);
      run_traffic(30);
      drain_results();

      // Display back, a stretch with no idling
      write_reg(CSR_DISPLAY_PRESENT, 8'h01);
      idle_on = 1'b0;
      run_traffic(60);
      drain_results();

      // Random attribute, sender pauses mid-phase until results catch up
      idle_on = 1'b1;
      write_reg(CSR_TEXT_ATTR, CSR_DATA_W'($urandom_range(0, 255)));
      run_traffic(60);
      drain_results();
      run_traffic(60);
      drain_results();

      // Closing part with no idling on either side
      write_reg(CSR_TEXT_ATTR, CSR_DATA_W'($urandom_range(0, 255)));
      idle_on = 1'b0;
      run_traffic(110);
      drain_results();
      repeat (8) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("text_console_char_writer test passed");
      else
         $display("text_console_char_writer test failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/tccw_pkg.sv
rtl/text_console_char_writer.sv
test/tccw_console_checker.sv
test/tb_text_console_char_writer.sv
